### rtl/dns_name_label_encoder_unit_macros.svh
// assertion macros used by the label encoder rtl
`ifndef DNS_NAME_LABEL_ENCODER_UNIT_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DNLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dnle assertion failed");

// next-cycle implication, checked outside reset
`define DNLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dnle assertion failed");

`endif

### rtl/dnle_pkg.sv
// types and constants of the dns name label encoder
package dnle_pkg;

  localparam int CHAR_W = 8;
  localparam int LCNT_W = 6;
  localparam int NCNT_W = 8;
  localparam int TOT_W  = 9;
  localparam int STAT_W = 2;

  // special characters of the dotted name
  localparam logic [CHAR_W-1:0] NUL_CHAR = 8'd0;
  localparam logic [CHAR_W-1:0] DOT_CHAR = 8'd46;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NAME_LONG  = 2'd1;
  localparam logic [STAT_W-1:0] ST_LABEL_LONG = 2'd2;

  // label memory control from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

### rtl/dnle_if.sv
// stream interfaces for name characters and encoded bytes
interface dnle_char_if;
  import dnle_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

interface dnle_byte_if;
  import dnle_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_byte;
  logic              last;
  logic              name_end;
  logic [STAT_W-1:0] status;
  logic [TOT_W-1:0]  total_len;

  modport source (output valid, output out_byte, output last, output name_end,
                  output status, output total_len, input ready);
  modport sink (input valid, input out_byte, input last, input name_end,
                input status, input total_len, output ready);
endinterface

### rtl/dnle_label_mem.sv
// label character buffer: one write and one registered read port
module dnle_label_mem #(
  parameter int DEPTH = 62,
  parameter int AW    = 6
) (
  input  logic                      clk_i,
  input  dnle_pkg::mem_ctl_t        ctl_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [dnle_pkg::CHAR_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [dnle_pkg::CHAR_W-1:0] rdata_o
);
  import dnle_pkg::*;

  logic [CHAR_W-1:0] label_mem_q [DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      label_mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= label_mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dns_name_label_encoder_unit.sv
// dns name label encoder: sequencer, output register and label buffer
//
// Usage: characters of a dotted host name enter on in_ch, one per transfer,
// and a zero character ends the name. Encoded bytes leave on out_ch.
// A plain character only goes into the label buffer and gives no output.
// A dot gives the label length byte in the cycle after its transfer, then
// each buffered character follows, read through the registered read port
// of the label memory in states S_RD and S_DATA. A terminator does the same
// and adds a closing zero byte carrying name_end and the encoded length. An
// error (name or label too long) gives a single byte with name_end set, and
// the rest of the name up to its terminator is dropped. in_ch is ready only
// while no label is being read out and the output register is free or being
// emptied; a stalled receiver holds the byte in the output register and
// stops everything behind it. Reset clears the counts, the discard flag and
// the output valid and sets max_name_len to 255; the label memory needs no
// clearing. cfg_we_i with cfg_wdata_i writes max_name_len; the user must
// write it only while the block is idle, which the block does not enforce.
module dns_name_label_encoder_unit #(
  parameter int MAX_LABEL = 62
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dnle_pkg::NCNT_W-1:0] cfg_wdata_i,
  dnle_char_if.sink                   in_ch,
  dnle_byte_if.source                 out_ch
);
  import dnle_pkg::*;

  `include "dns_name_label_encoder_unit_macros.svh"

  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_ZERO = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [LCNT_W-1:0] lcnt_q, lcnt_d;
  logic [LCNT_W-1:0] idx_q, idx_d;
  logic [NCNT_W-1:0] ncnt_q, ncnt_d;
  logic [NCNT_W-1:0] max_len_q;
  logic              disc_q, disc_d;
  logic              term_q, term_d;
  logic [TOT_W-1:0]  tot_q, tot_d;

  logic              out_vld_q, out_vld_d;
  logic [CHAR_W-1:0] ob_q, ob_d;
  logic              olast_q, olast_d;
  logic              oend_q, oend_d;
  logic [STAT_W-1:0] ostat_q, ostat_d;
  logic [TOT_W-1:0]  otot_q, otot_d;
  logic              out_load;

  logic              can_load;
  logic              in_fire;
  logic [CHAR_W-1:0] ch;
  logic              last_idx;
  logic              name_over;
  mem_ctl_t          mem_ctl;
  logic [CHAR_W-1:0] rdata;

  assign can_load  = !out_vld_q || out_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE) && can_load;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign ch        = in_ch.in_char;
  assign last_idx  = (idx_q + LCNT_W'(1)) == lcnt_q;
  assign name_over = (max_len_q == '0) ||
                     ((ch != NUL_CHAR) &&
                      (({1'b0, ncnt_q} + 9'd1) >= {1'b0, max_len_q}));

  // label buffer
  dnle_label_mem #(
    .DEPTH(MAX_LABEL),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .waddr_i(lcnt_q[AW-1:0]),
    .wdata_i(ch),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // sequencer next state
  always_comb begin
    state_d  = state_q;
    lcnt_d   = lcnt_q;
    idx_d    = idx_q;
    ncnt_d   = ncnt_q;
    disc_d   = disc_q;
    term_d   = term_q;
    tot_d    = tot_q;
    out_load = 1'b0;
    ob_d     = ob_q;
    olast_d  = olast_q;
    oend_d   = oend_q;
    ostat_d  = ostat_q;
    otot_d   = otot_q;
    mem_ctl  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (disc_q) begin
            // drop up to the terminator
            if (ch == NUL_CHAR) begin
              disc_d = 1'b0;
            end
          end else if (name_over || ((ch != NUL_CHAR) && (ch != DOT_CHAR) &&
                                     (lcnt_q >= LCNT_W'(MAX_LABEL)))) begin
            // error result, then discard the rest of the name
            out_load = 1'b1;
            ob_d     = '0;
            olast_d  = 1'b1;
            oend_d   = 1'b1;
            ostat_d  = name_over ? ST_NAME_LONG : ST_LABEL_LONG;
            otot_d   = '0;
            lcnt_d   = '0;
            ncnt_d   = '0;
            disc_d   = 1'b1;
          end else if ((ch == NUL_CHAR) || (ch == DOT_CHAR)) begin
            // label length byte, then the buffered label
            out_load = 1'b1;
            ob_d     = {{(CHAR_W-LCNT_W){1'b0}}, lcnt_q};
            oend_d   = 1'b0;
            ostat_d  = ST_OK;
            otot_d   = '0;
            idx_d    = '0;
            tot_d    = {1'b0, ncnt_q} + 9'd2;
            if (ch == NUL_CHAR) begin
              olast_d = 1'b0;
              term_d  = 1'b1;
              ncnt_d  = '0;
              state_d = (lcnt_q == '0) ? S_ZERO : S_RD;
            end else begin
              olast_d = (lcnt_q == '0);
              term_d  = 1'b0;
              ncnt_d  = ncnt_q + NCNT_W'(1);
              state_d = (lcnt_q == '0) ? S_IDLE : S_RD;
            end
          end else begin
            // buffer a label character
            mem_ctl.wr_en = 1'b1;
            lcnt_d        = lcnt_q + LCNT_W'(1);
            ncnt_d        = ncnt_q + NCNT_W'(1);
          end
        end
      end
      S_RD: begin
        mem_ctl.rd_en = 1'b1;
        state_d       = S_DATA;
      end
      S_DATA: begin
        if (can_load) begin
          out_load = 1'b1;
          ob_d     = rdata;
          olast_d  = last_idx && !term_q;
          oend_d   = 1'b0;
          ostat_d  = ST_OK;
          otot_d   = '0;
          if (last_idx) begin
            lcnt_d  = '0;
            state_d = term_q ? S_ZERO : S_IDLE;
          end else begin
            idx_d   = idx_q + LCNT_W'(1);
            state_d = S_RD;
          end
        end
      end
      S_ZERO: begin
        // closing zero byte with the encoded length
        if (can_load) begin
          out_load = 1'b1;
          ob_d     = '0;
          olast_d  = 1'b1;
          oend_d   = 1'b1;
          ostat_d  = ST_OK;
          otot_d   = tot_q;
          lcnt_d   = '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_vld_d = out_vld_q && !out_ch.ready;
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lcnt_q    <= '0;
      idx_q     <= '0;
      ncnt_q    <= '0;
      disc_q    <= 1'b0;
      term_q    <= 1'b0;
      out_vld_q <= 1'b0;
      max_len_q <= 8'd255;
    end else begin
      state_q   <= state_d;
      lcnt_q    <= lcnt_d;
      idx_q     <= idx_d;
      ncnt_q    <= ncnt_d;
      disc_q    <= disc_d;
      term_q    <= term_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tot_q   <= tot_d;
    ob_q    <= ob_d;
    olast_q <= olast_d;
    oend_q  <= oend_d;
    ostat_q <= ostat_d;
    otot_q  <= otot_d;
  end

  assign out_ch.valid     = out_vld_q;
  assign out_ch.out_byte  = ob_q;
  assign out_ch.last      = olast_q;
  assign out_ch.name_end  = oend_q;
  assign out_ch.status    = ostat_q;
  assign out_ch.total_len = otot_q;

  // checks on the sequencer and buffer
  `DNLE_ASSERT_IMPL(a_lcnt_bound, clk_i, rst_ni, 1'b1, lcnt_q <= LCNT_W'(MAX_LABEL))
  `DNLE_ASSERT_IMPL(a_rd_in_label, clk_i, rst_ni, mem_ctl.rd_en, idx_q < lcnt_q)
  `DNLE_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_vld_q && (ostat_q != ST_OK), oend_q && olast_q && (ob_q == '0) && (otot_q == '0))
  `DNLE_ASSERT_NEXT(a_load_valid, clk_i, rst_ni, out_load, out_vld_q)

endmodule
